// ===== design/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer pool package
// Shared codes, types and the command/status structs between the controller
// and the datapath of the software timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    // Operation codes of an input item.
    localparam logic [3:0] FUNC_TICK    = 4'd0;
    localparam logic [3:0] FUNC_SCAN    = 4'd1;
    localparam logic [3:0] FUNC_ALLOC   = 4'd2;
    localparam logic [3:0] FUNC_START   = 4'd3;
    localparam logic [3:0] FUNC_STOP    = 4'd4;
    localparam logic [3:0] FUNC_RELEASE = 4'd5;
    localparam logic [3:0] FUNC_POLL    = 4'd6;
    localparam logic [3:0] FUNC_SETREP  = 4'd7;
    localparam logic [3:0] FUNC_READ    = 4'd8;

    // Result kinds.
    localparam logic [2:0] KIND_ACK   = 3'd0;
    localparam logic [2:0] KIND_ALLOC = 3'd1;
    localparam logic [2:0] KIND_POLL  = 3'd2;
    localparam logic [2:0] KIND_EVENT = 3'd3;
    localparam logic [2:0] KIND_TICKS = 3'd4;

    // Slot states.
    typedef logic [1:0] t_slot_state;
    localparam t_slot_state SLOT_UNUSED  = 2'd0;
    localparam t_slot_state SLOT_RUNNING = 2'd1;
    localparam t_slot_state SLOT_STOPPED = 2'd2;
    localparam t_slot_state SLOT_EXPIRED = 2'd3;

    // Upper bound on expiry events reported by one scan.
    localparam int MAX_EVENTS = 8;
    localparam int EVT_CNT_W  = $clog2(MAX_EVENTS + 1);

    typedef struct packed {
        logic op_exec;      // operation on the input fields that needs no walk
        logic scan_init;
        logic scan_run;
        logic scan_finish;
        logic alloc_init;
        logic alloc_run;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic alloc_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/stp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/stp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Timer pool controller
// Accepts commands and sequences the scan and allocate walks of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_ctrl
    import stp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [3:0] i_func,
    input  wire t_sts       i_sts,
    output logic            o_busy,
    output t_cmd            o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        FUNC_SCAN: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_SCAN;
                        end
                        FUNC_ALLOC: begin
                            o_cmd.alloc_init = 1'b1;
                            n_state          = ST_ALLOC;
                        end
                        default: begin
                            o_cmd.op_exec = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            ST_ALLOC: begin
                o_cmd.alloc_run = 1'b1;
                if (i_sts.alloc_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/stp_dp.sv =====
// ----------------------------------------------------------------------------
// Timer pool datapath
// Tick counter, slot state flops, stamp and duration RAMs, scan pipeline,
// allocation walk and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_dp
    import stp_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [3:0]  i_func,
    input  wire logic [7:0]  i_slot_id,
    input  wire logic [15:0] i_duration_ticks,
    input  wire logic        i_repeat_enable,
    output logic             o_strobe,
    output logic [2:0]       o_result_kind,
    output logic             o_result_ok,
    output logic [2:0]       o_slot_index,
    output logic [31:0]      o_tick_value,
    output logic             o_last
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [7:0]           SLOT_LIMIT = 8'(SLOT_COUNT);
    localparam logic [IW-1:0]        LAST_IDX   = IW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0]        END_IDX    = CW'(SLOT_COUNT);
    localparam logic [EVT_CNT_W-1:0] EVT_LIMIT  = EVT_CNT_W'(MAX_EVENTS);

    // Architectural state.
    logic [31:0]       r_tick,   n_tick;
    t_slot_state       r_status [SLOT_COUNT];
    t_slot_state       n_status [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_repeat, n_repeat;

    // Walk control for scan and allocate.
    logic              r_walk,     n_walk;
    logic [IW-1:0]     r_idx,      n_idx;
    logic [CW-1:0]     r_rd_idx,   n_rd_idx;
    logic              r_ev_vld,   n_ev_vld;
    logic [EVT_CNT_W-1:0] r_cnt,   n_cnt;
    logic              r_pend_vld, n_pend_vld;
    logic [IW-1:0]     r_pend_idx, n_pend_idx;

    // Result register.
    logic              r_out_vld,  n_out_vld;
    logic [2:0]        r_kind,     n_kind;
    logic              r_ok,       n_ok;
    logic [2:0]        r_slot,     n_slot;
    logic [31:0]       r_tickv,    n_tickv;
    logic              r_last,     n_last;

    logic [IW-1:0]     s_idx;
    t_slot_state       s_stat;
    logic              id_valid;
    logic [31:0]       stamp_rd;
    logic [15:0]       dur_rd;
    logic [31:0]       elapsed;
    logic              due;
    logic              issue_ok;
    logic              stamp_we;
    logic              dur_we;

    // During a walk the slot state is read at the walk index, otherwise at
    // the slot named by the command.
    assign s_idx    = r_walk ? r_idx : i_slot_id[IW-1:0];
    assign s_stat   = r_status[s_idx];
    assign id_valid = (i_slot_id < SLOT_LIMIT);
    assign elapsed  = r_tick - stamp_rd;
    assign due      = (elapsed[31:16] != 16'd0) || (elapsed[15:0] >= dur_rd);
    assign issue_ok = (r_rd_idx != END_IDX) && (r_cnt != EVT_LIMIT);

    assign o_sts.scan_done  = !r_ev_vld && ((r_rd_idx == END_IDX) || (r_cnt == EVT_LIMIT));
    assign o_sts.alloc_done = (s_stat == SLOT_UNUSED) || (r_idx == LAST_IDX);

    stp_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_COUNT)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (s_idx),
        .i_wdata (r_tick),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (stamp_rd)
    );

    stp_ram #(
        .WIDTH (16),
        .DEPTH (SLOT_COUNT)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (dur_we),
        .i_waddr (s_idx),
        .i_wdata (i_duration_ticks),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (dur_rd)
    );

    always_comb begin
        n_tick     = r_tick;
        n_status   = r_status;
        n_repeat   = r_repeat;
        n_walk     = r_walk;
        n_idx      = r_idx;
        n_rd_idx   = r_rd_idx;
        n_ev_vld   = 1'b0;
        n_cnt      = r_cnt;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_out_vld  = 1'b0;
        n_kind     = KIND_ACK;
        n_ok       = 1'b0;
        n_slot     = 3'd0;
        n_tickv    = 32'd0;
        n_last     = 1'b1;
        stamp_we   = 1'b0;
        dur_we     = 1'b0;

        if (i_cmd.op_exec) begin
            n_out_vld = 1'b1;
            case (i_func)
                FUNC_TICK: begin
                    n_tick = r_tick + 32'd1;
                    n_ok   = 1'b1;
                end
                FUNC_START: begin
                    if (id_valid && (s_stat != SLOT_UNUSED)) begin
                        n_ok            = 1'b1;
                        stamp_we        = 1'b1;
                        dur_we          = 1'b1;
                        n_status[s_idx] = SLOT_RUNNING;
                    end
                end
                FUNC_STOP: begin
                    if (id_valid) begin
                        n_ok            = 1'b1;
                        n_status[s_idx] = SLOT_STOPPED;
                    end
                end
                FUNC_RELEASE: begin
                    if (id_valid) begin
                        n_ok            = 1'b1;
                        n_status[s_idx] = SLOT_UNUSED;
                    end
                end
                FUNC_POLL: begin
                    n_kind = KIND_POLL;
                    if (id_valid && (s_stat == SLOT_EXPIRED)) begin
                        n_ok            = 1'b1;
                        n_status[s_idx] = SLOT_STOPPED;
                    end
                end
                FUNC_SETREP: begin
                    if (id_valid) begin
                        n_ok            = 1'b1;
                        n_repeat[s_idx] = i_repeat_enable;
                    end
                end
                FUNC_READ: begin
                    n_kind  = KIND_TICKS;
                    n_ok    = 1'b1;
                    n_tickv = r_tick;
                end
                FUNC_SCAN, FUNC_ALLOC: begin
                    n_out_vld = 1'b0;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end

        if (i_cmd.scan_init) begin
            n_walk     = 1'b1;
            n_rd_idx   = '0;
            n_cnt      = '0;
            n_pend_vld = 1'b0;
        end

        if (i_cmd.scan_run) begin
            // Read stage: fetch stamp and duration of the next slot.
            if (issue_ok) begin
                n_ev_vld = 1'b1;
                n_idx    = r_rd_idx[IW-1:0];
                n_rd_idx = r_rd_idx + CW'(1);
            end
            // Evaluate stage. An event is held back one find so that the
            // final one of the scan can carry the last flag.
            if (r_ev_vld && (r_cnt != EVT_LIMIT) && (s_stat == SLOT_RUNNING) && due) begin
                if (r_repeat[r_idx]) begin
                    stamp_we = 1'b1;
                end else begin
                    n_status[r_idx] = SLOT_EXPIRED;
                end
                if (r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_kind    = KIND_EVENT;
                    n_ok      = 1'b1;
                    n_slot    = 3'(r_pend_idx);
                    n_last    = 1'b0;
                end
                n_pend_vld = 1'b1;
                n_pend_idx = r_idx;
                n_cnt      = r_cnt + EVT_CNT_W'(1);
            end
        end

        if (i_cmd.scan_finish) begin
            n_walk    = 1'b0;
            n_out_vld = 1'b1;
            if (r_pend_vld) begin
                n_kind = KIND_EVENT;
                n_ok   = 1'b1;
                n_slot = 3'(r_pend_idx);
            end
        end

        if (i_cmd.alloc_init) begin
            n_walk = 1'b1;
            n_idx  = '0;
        end

        if (i_cmd.alloc_run) begin
            if (s_stat == SLOT_UNUSED) begin
                n_status[r_idx] = SLOT_STOPPED;
                n_repeat[r_idx] = 1'b0;
                n_walk          = 1'b0;
                n_out_vld       = 1'b1;
                n_kind          = KIND_ALLOC;
                n_ok            = 1'b1;
                n_slot          = 3'(r_idx);
            end else if (r_idx == LAST_IDX) begin
                n_walk    = 1'b0;
                n_out_vld = 1'b1;
                n_kind    = KIND_ALLOC;
            end else begin
                n_idx = r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= 32'd0;
            r_repeat   <= '0;
            r_walk     <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_rd_idx   <= '0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_status[i] <= SLOT_UNUSED;
            end
        end else begin
            r_tick     <= n_tick;
            r_repeat   <= n_repeat;
            r_walk     <= n_walk;
            r_ev_vld   <= n_ev_vld;
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_rd_idx   <= n_rd_idx;
            r_out_vld  <= n_out_vld;
            r_status   <= n_status;
        end
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_kind     <= n_kind;
        r_ok       <= n_ok;
        r_slot     <= n_slot;
        r_tickv    <= n_tickv;
        r_last     <= n_last;
    end

    assign o_strobe      = r_out_vld;
    assign o_result_kind = r_kind;
    assign o_result_ok   = r_ok;
    assign o_slot_index  = r_slot;
    assign o_tick_value  = r_tickv;
    assign o_last        = r_last;

    // A scan never reports more events than the per-scan limit.
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= EVT_LIMIT)
        else $error("scan event count beyond limit");

    // Only an expiry event can leave a run open.
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_kind != KIND_EVENT) |-> r_last)
        else $error("non-event result without last flag");

    // Every scan or allocate walk closes with a final result.
    a_walk_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_walk) |-> r_out_vld && r_last)
        else $error("walk ended without a final result");

    // The scan evaluate stage is only busy inside a walk.
    a_ev_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> r_walk)
        else $error("scan evaluation outside a walk");

endmodule

`default_nettype wire

// ===== design/software_timer_pool_unit.sv =====
// ----------------------------------------------------------------------------
// Software timer pool unit
// A pool of SLOT_COUNT timers driven by a 32-bit tick counter.
// ----------------------------------------------------------------------------
// Usage: present an operation on i_func with its operands and raise start;
// the transfer happens at a rising edge where start is high and busy is low.
// Results leave on the o_ ports for exactly one cycle, marked by o_strobe,
// and the receiver cannot hold them off. o_last marks the final result of
// the run caused by one transfer.
// Tick, start, stop, release, poll, set repeat and read ticks need no walk:
// their single result appears the cycle after the transfer and busy stays
// low, so one of these can be taken every cycle.
// Allocate walks the slot state one slot per cycle; its result appears in
// the same cycle that busy falls.
// Scan reads stamp and duration of one slot per cycle from the slot RAMs
// through a two-stage read/evaluate pipeline and stops early once eight
// events are found; events stream out in ascending slot order, the final
// one in the same cycle that busy falls.
// Reset clears the tick count and marks every slot unused; stamps and
// durations need no clearing since they are only used for running slots.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_pool_unit
    import stp_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_func,
    input  wire logic [7:0]  i_slot_id,
    input  wire logic [15:0] i_duration_ticks,
    input  wire logic        i_repeat_enable,
    output logic             o_strobe,
    output logic [2:0]       o_result_kind,
    output logic             o_result_ok,
    output logic [2:0]       o_slot_index,
    output logic [31:0]      o_tick_value,
    output logic             o_last
);

    t_cmd cmd;
    t_sts sts;

    stp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    stp_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (i_func),
        .i_slot_id        (i_slot_id),
        .i_duration_ticks (i_duration_ticks),
        .i_repeat_enable  (i_repeat_enable),
        .o_strobe         (o_strobe),
        .o_result_kind    (o_result_kind),
        .o_result_ok      (o_result_ok),
        .o_slot_index     (o_slot_index),
        .o_tick_value     (o_tick_value),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Software timer pool unit testbench
// Drives tick, scan, allocate, start, stop, release, poll, set repeat and
// read operations in bursts with random gaps, predicts every result from a
// behavioral copy of the timer pool, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    localparam int SLOTS = 8;
    localparam int RANDOM_OPS = 433;
    localparam logic [3:0] FUNC_LAST_CODE = 4'hF;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [2:0]  slot;
        logic [31:0] ticks;
        logic        last;
    } t_pool_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_func = '0;
    logic [7:0]  i_slot_id = '0;
    logic [15:0] i_duration_ticks = '0;
    logic        i_repeat_enable = 1'b0;
    logic        o_strobe;
    logic [2:0]  o_result_kind;
    logic        o_result_ok;
    logic [2:0]  o_slot_index;
    logic [31:0] o_tick_value;
    logic        o_last;

    // Predicted pool state.
    logic [31:0] tick_now;
    t_slot_state slot_state [SLOTS];
    logic [31:0] slot_stamp [SLOTS];
    logic [15:0] slot_dur [SLOTS];
    logic        slot_repeat [SLOTS];

    t_pool_answer pool_answers[$];
    int errors = 0;
    int burst_left = 0;

    software_timer_pool_unit #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_slot_id       (i_slot_id),
        .i_duration_ticks(i_duration_ticks),
        .i_repeat_enable (i_repeat_enable),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_result_ok     (o_result_ok),
        .o_slot_index    (o_slot_index),
        .o_tick_value    (o_tick_value),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic void queue_answer(input logic [2:0] kind, input logic ok,
                                         input logic [2:0] slot, input logic [31:0] ticks);
        t_pool_answer ans;
        ans.kind = kind;
        ans.ok = ok;
        ans.slot = slot;
        ans.ticks = ticks;
        ans.last = 1'b0;
        pool_answers.push_back(ans);
    endfunction

    function automatic void clear_pool();
        tick_now = '0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_state[s] = SLOT_UNUSED;
            slot_stamp[s] = '0;
            slot_dur[s] = '0;
            slot_repeat[s] = 1'b0;
        end
    endfunction

    // Applies one operation to the predicted pool and queues its results.
    function automatic void run_pool_op(input logic [3:0] func, input logic [7:0] id,
                                        input logic [15:0] dur, input logic rep);
        t_pool_answer tail;
        logic         in_range;
        logic         found;
        logic [31:0]  elapsed;
        int           fired;
        int           sel;
        in_range = (int'(id) < SLOTS);
        sel = in_range ? int'(id) : 0;
        case (func)
            FUNC_TICK: begin
                tick_now = tick_now + 32'd1;
                queue_answer(KIND_ACK, 1'b1, '0, '0);
            end
            FUNC_SCAN: begin
                fired = 0;
                for (int s = 0; s < SLOTS && fired < MAX_EVENTS; s++) begin
                    elapsed = tick_now - slot_stamp[s];
                    if (slot_state[s] == SLOT_RUNNING && elapsed >= 32'(slot_dur[s])) begin
                        if (slot_repeat[s]) slot_stamp[s] = tick_now;
                        else slot_state[s] = SLOT_EXPIRED;
                        queue_answer(KIND_EVENT, 1'b1, 3'(s), '0);
                        fired++;
                    end
                end
                if (fired == 0) queue_answer(KIND_ACK, 1'b0, '0, '0);
            end
            FUNC_ALLOC: begin
                found = 1'b0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!found && slot_state[s] == SLOT_UNUSED) begin
                        slot_state[s] = SLOT_STOPPED;
                        slot_repeat[s] = 1'b0;
                        found = 1'b1;
                        queue_answer(KIND_ALLOC, 1'b1, 3'(s), '0);
                    end
                end
                if (!found) queue_answer(KIND_ALLOC, 1'b0, '0, '0);
            end
            FUNC_START: begin
                found = in_range && slot_state[sel] != SLOT_UNUSED;
                if (found) begin
                    slot_stamp[sel] = tick_now;
                    slot_dur[sel] = dur;
                    slot_state[sel] = SLOT_RUNNING;
                end
                queue_answer(KIND_ACK, found, '0, '0);
            end
            FUNC_STOP: begin
                if (in_range) slot_state[sel] = SLOT_STOPPED;
                queue_answer(KIND_ACK, in_range, '0, '0);
            end
            FUNC_RELEASE: begin
                if (in_range) slot_state[sel] = SLOT_UNUSED;
                queue_answer(KIND_ACK, in_range, '0, '0);
            end
            FUNC_POLL: begin
                found = in_range && slot_state[sel] == SLOT_EXPIRED;
                if (found) slot_state[sel] = SLOT_STOPPED;
                queue_answer(KIND_POLL, found, '0, '0);
            end
            FUNC_SETREP: begin
                if (in_range) slot_repeat[sel] = rep;
                queue_answer(KIND_ACK, in_range, '0, '0);
            end
            FUNC_READ: begin
                queue_answer(KIND_TICKS, 1'b1, '0, tick_now);
            end
            default: begin
                queue_answer(KIND_ACK, 1'b0, '0, '0);
            end
        endcase
        tail = pool_answers.pop_back();
        tail.last = 1'b1;
        pool_answers.push_back(tail);
    endfunction

    // Sends one operation; bursts of transfers are separated by random gaps.
    task automatic issue_op(input logic [3:0] func, input logic [7:0] id,
                            input logic [15:0] dur, input logic rep);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 90);
            else burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start <= 1'b1;
        i_func <= func;
        i_slot_id <= id;
        i_duration_ticks <= dur;
        i_repeat_enable <= rep;
        do @(posedge i_clk); while (busy);
        run_pool_op(func, id, dur, rep);
    endtask

    always @(posedge i_clk) begin
        t_pool_answer got;
        t_pool_answer want;
        if (i_rst_n && o_strobe) begin
            got = {o_result_kind, o_result_ok, o_slot_index, o_tick_value, o_last};
            if (pool_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind %0d ok %0d slot %0d ticks %0d last %0d",
                         $time, got.kind, got.ok, got.slot, got.ticks, got.last);
            end else begin
                want = pool_answers.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected kind %0d ok %0d slot %0d ticks %0d last %0d",
                             $time, want.kind, want.ok, want.slot, want.ticks, want.last);
                    $display("%0t:            actual kind %0d ok %0d slot %0d ticks %0d last %0d",
                             $time, got.kind, got.ok, got.slot, got.ticks, got.last);
                end
            end
        end
    end

    task automatic test_empty_pool();
        issue_op(FUNC_SCAN, 8'd0, 16'd0, 1'b0);
        issue_op(FUNC_START, 8'd3, 16'd5, 1'b0);
    endtask

    // The ninth allocation finds no free slot.
    task automatic test_alloc_all();
        repeat (SLOTS + 1) issue_op(FUNC_ALLOC, 8'd0, 16'd0, 1'b0);
    endtask

    task automatic test_scan_all_due();
        for (int s = 0; s < SLOTS; s++) issue_op(FUNC_START, 8'(s), 16'd0, 1'b0);
        issue_op(FUNC_SCAN, 8'd0, 16'd0, 1'b0);
        issue_op(FUNC_POLL, 8'd0, 16'd0, 1'b0);
    endtask

    task automatic test_out_of_range();
        issue_op(FUNC_START, 8'hFF, 16'hFFFF, 1'b1);
        issue_op(FUNC_SETREP, 8'hFF, 16'hFFFF, 1'b1);
        issue_op(FUNC_POLL, 8'(SLOTS), 16'd0, 1'b0);
    endtask

    task automatic test_unknown_func();
        issue_op(FUNC_LAST_CODE, 8'hFF, 16'hFFFF, 1'b1);
    endtask

    task automatic test_tick_read();
        issue_op(FUNC_TICK, 8'd0, 16'd0, 1'b0);
        issue_op(FUNC_READ, 8'd0, 16'd0, 1'b0);
    endtask

    // Weighted toward ticks, starts and scans so that slots actually fire,
    // with some repeat changes, polls, releases and stray ids mixed in.
    task automatic test_random_ops();
        logic [3:0]  func;
        logic [7:0]  id;
        logic [15:0] dur;
        int          pick;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) func = FUNC_TICK;
            else if (pick < 40) func = FUNC_SCAN;
            else if (pick < 48) func = FUNC_ALLOC;
            else if (pick < 63) func = FUNC_START;
            else if (pick < 68) func = FUNC_STOP;
            else if (pick < 73) func = FUNC_RELEASE;
            else if (pick < 83) func = FUNC_POLL;
            else if (pick < 92) func = FUNC_SETREP;
            else if (pick < 97) func = FUNC_READ;
            else func = 4'($urandom_range(int'(FUNC_READ) + 1, int'(FUNC_LAST_CODE)));
            if ($urandom_range(0, 9) == 0) id = 8'($urandom_range(0, 255));
            else id = 8'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 9) == 0) dur = 16'($urandom_range(0, 65535));
            else dur = 16'($urandom_range(0, 12));
            issue_op(func, id, dur, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        clear_pool();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_pool();
        test_alloc_all();
        test_scan_all_due();
        test_out_of_range();
        test_unknown_func();
        test_tick_read();
        test_random_ops();
        start <= 1'b0;
        wait (pool_answers.size() == 0);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/stp_pkg.sv
design/stp_ram.sv
design/stp_ctrl.sv
design/stp_dp.sv
design/software_timer_pool_unit.sv
sim/testbench.sv
